@@ rtl/tkhq_pkg.sv @@
// ----------------------------------------------------------------------------
// tkhq_pkg
// shared types and constants for the three-key min-heap queue
// ----------------------------------------------------------------------------
`default_nettype none

package tkhq_pkg;

  localparam int KEY_W   = 63;
  localparam int STAMP_W = 32;
  localparam int TAG_W   = 16;
  localparam int OCC_W   = 11;

  // action codes of an input word
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } tkhq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LOAD,
    S_DN_RD,
    S_DN_CMPL,
    S_DN_CMPR
  } tkhq_state_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] primary_key;
    logic [KEY_W-1:0] secondary_key;
    logic [TAG_W-1:0] tag;
  } tkhq_in_t;

  typedef struct packed {
    tkhq_status_t     status;
    logic [KEY_W-1:0] out_primary_key;
    logic [KEY_W-1:0] out_secondary_key;
    logic [TAG_W-1:0] out_tag;
    logic [OCC_W-1:0] occupancy;
  } tkhq_out_t;

endpackage

`default_nettype wire

@@ rtl/tkhq_ram.sv @@
// ----------------------------------------------------------------------------
// tkhq_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module tkhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

@@ rtl/three_key_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// three_key_min_heap_queue
// binary min-heap priority queue ordered by primary key, secondary key and
// insertion stamp, with one shared comparator walking the heap
// ----------------------------------------------------------------------------
//
//  channel  ports                     handshake
//  -------  ------------------------  -----------------------------------
//  input    start, busy, in_word      word taken when start && !busy
//  result   out_valid, out_word       one-cycle strobe, cannot be held off
//
//  an insert holds busy while it climbs the heap, a pop while the last entry
//  sifts down from the root, stopping in a leaf or where a compare stops it;
//  a pop that empties the heap skips the sift. the walk is paced by the
//  registered heap ram read and the single key comparator, one compare per
//  cycle. the result is strobed in the same cycle as busy falls. a pop on
//  empty or insert into a full heap answers the next cycle without raising
//  busy. reset clears state, count, stamp and the result strobe; the heap
//  ram needs no clearing pass. the result side cannot stall.
//
`default_nettype none

module three_key_min_heap_queue
  import tkhq_pkg::*;
#(
  parameter int ENTRIES  = 1024,
  parameter int TAG_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire tkhq_in_t  in_word,
  output logic           out_valid,
  output tkhq_out_t      out_word
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // one heap slot as held in the ram
  typedef struct packed {
    logic [KEY_W-1:0]    pk;
    logic [KEY_W-1:0]    sk;
    logic [STAMP_W-1:0]  st;
    logic [TAG_BITS-1:0] tg;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // count of entries held, reduced to the occupancy field
  function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
    logic [CW+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

  // stored tag widened or cut to the result field
  function automatic logic [TAG_W-1:0] tag_out(input logic [TAG_BITS-1:0] t);
    logic [TAG_BITS+TAG_W-1:0] w;
    w = {{TAG_W{1'b0}}, t};
    return w[TAG_W-1:0];
  endfunction

  // incoming tag, only the low TAG_BITS bits are kept
  function automatic logic [TAG_BITS-1:0] tag_in(input logic [TAG_W-1:0] t);
    logic [TAG_BITS+TAG_W-1:0] w;
    w = {{TAG_BITS{1'b0}}, t};
    return w[TAG_BITS-1:0];
  endfunction

  tkhq_state_t       state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic              out_valid_r, out_valid_nxt;
  tkhq_out_t         out_word_r, out_word_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;        // slot of the hole, from 1
  entry_t            cur_r, cur_nxt;        // entry being sifted
  entry_t            best_r, best_nxt;      // smaller of cur and left child
  logic              left_r, left_nxt;      // left child won the first compare

  // heap ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr_a, ram_raddr_b;
  logic [EW-1:0] ram_rdata_a, ram_rdata_b;
  entry_t        rd_a, rd_b;

  // shared comparator
  entry_t cmp_x, cmp_y;
  logic   cmp_less;

  // slot arithmetic
  logic          accept;
  logic          full;
  logic [CW:0]   pos_x2;
  logic [CW:0]   r_slot;
  logic [CW:0]   l_addr_w;
  logic          l_valid, r_valid;
  logic [CW-1:0] par_slot;
  logic [CW-1:0] par_addr_w;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_p1;
  logic [STAMP_W-1:0] stamp_p1;

  tkhq_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_heap (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr_a (ram_raddr_a),
    .rd_data_a (ram_rdata_a),
    .rd_addr_b (ram_raddr_b),
    .rd_data_b (ram_rdata_b)
  );

  assign rd_a = entry_t'(ram_rdata_a);
  assign rd_b = entry_t'(ram_rdata_b);

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == CW'(ENTRIES));
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // children of the hole are slots 2p and 2p+1, ram addresses 2p-1 and 2p
  assign pos_x2     = {pos_r, 1'b0};
  assign r_slot     = pos_x2 + (CW+1)'(1);
  assign l_addr_w   = pos_x2 - (CW+1)'(1);
  assign l_valid    = (pos_x2 <= {1'b0, count_r});
  assign r_valid    = (r_slot <= {1'b0, count_r});
  assign par_slot   = pos_r >> 1;
  assign par_addr_w = par_slot - CW'(1);
  assign pos_m1     = pos_r - CW'(1);
  assign cnt_m1     = count_r - CW'(1);
  assign cnt_p1     = count_r + CW'(1);
  assign stamp_p1   = stamp_r + STAMP_W'(1);

  // read addresses follow the hole, so data stays put while it is compared
  always_comb begin
    unique case (state_r)
      S_UP_RD, S_UP_CMP: begin
        ram_raddr_a = par_addr_w[AW-1:0];
        ram_raddr_b = par_addr_w[AW-1:0];
      end
      S_POP_RD, S_POP_LOAD: begin
        ram_raddr_a = '0;
        ram_raddr_b = cnt_m1[AW-1:0];
      end
      default: begin
        ram_raddr_a = l_addr_w[AW-1:0];
        ram_raddr_b = pos_x2[AW-1:0];
      end
    endcase
  end

  // operand selection for the one comparator: x orders strictly before y
  always_comb begin
    unique case (state_r)
      S_UP_CMP: begin
        cmp_x = cur_r;
        cmp_y = rd_a;
      end
      S_DN_CMPL: begin
        cmp_x = rd_a;
        cmp_y = cur_r;
      end
      default: begin
        cmp_x = rd_b;
        cmp_y = best_r;
      end
    endcase
  end

  // lexicographic primary, secondary, stamp as one wide compare
  assign cmp_less = {cmp_x.pk, cmp_x.sk, cmp_x.st} < {cmp_y.pk, cmp_y.sk, cmp_y.st};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.action == ACT_INSERT) begin
            if (!full) begin
              state_nxt = S_UP_RD;
            end
          end else if (count_r != '0) begin
            state_nxt = S_POP_RD;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (pos_r == CW'(1)) ? S_IDLE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_nxt = cmp_less ? S_UP_RD : S_IDLE;
      end
      S_POP_RD: begin
        state_nxt = S_POP_LOAD;
      end
      S_POP_LOAD: begin
        state_nxt = (count_r == CW'(1)) ? S_IDLE : S_DN_RD;
      end
      S_DN_RD: begin
        state_nxt = l_valid ? S_DN_CMPL : S_IDLE;
      end
      S_DN_CMPL: begin
        state_nxt = S_DN_CMPR;
      end
      S_DN_CMPR: begin
        state_nxt = ((r_valid && cmp_less) || left_r) ? S_DN_RD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and ram controls
  always_comb begin
    count_nxt     = count_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    left_nxt      = left_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_m1[AW-1:0];
    ram_wdata     = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.action == ACT_INSERT) begin
            if (full) begin
              // dropped, stamp does not move
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: ST_FULL, out_primary_key: '0,
                                out_secondary_key: '0, out_tag: '0,
                                occupancy: occ_of(count_r)};
            end else begin
              count_nxt    = cnt_p1;
              stamp_nxt    = stamp_p1;
              pos_nxt      = cnt_p1;
              cur_nxt      = '{pk: in_word.primary_key, sk: in_word.secondary_key,
                               st: stamp_p1, tg: tag_in(in_word.tag)};
              out_word_nxt = '{status: ST_INSERTED, out_primary_key: '0,
                               out_secondary_key: '0, out_tag: '0,
                               occupancy: occ_of(cnt_p1)};
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_EMPTY, out_primary_key: '0,
                              out_secondary_key: '0, out_tag: '0,
                              occupancy: occ_of(count_r)};
          end
        end
      end
      S_UP_RD: begin
        // reached the root: drop the entry in place
        if (pos_r == CW'(1)) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_less) begin
          // parent moves down into the hole
          ram_wdata = rd_a;
          pos_nxt   = par_slot;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      S_POP_LOAD: begin
        // root goes out, last entry becomes the one to sift down
        out_word_nxt = '{status: ST_POPPED, out_primary_key: rd_a.pk,
                         out_secondary_key: rd_a.sk, out_tag: tag_out(rd_a.tg),
                         occupancy: occ_of(cnt_m1)};
        cur_nxt      = rd_b;
        count_nxt    = cnt_m1;
        pos_nxt      = CW'(1);
        if (count_r == CW'(1)) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_DN_RD: begin
        // no children left: entry settles here
        if (!l_valid) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      S_DN_CMPL: begin
        if (cmp_less) begin
          best_nxt = rd_a;
          left_nxt = 1'b1;
        end else begin
          best_nxt = cur_r;
          left_nxt = 1'b0;
        end
      end
      S_DN_CMPR: begin
        ram_we = 1'b1;
        priority if (r_valid && cmp_less) begin
          ram_wdata = rd_b;
          pos_nxt   = r_slot[CW-1:0];
        end else if (left_r) begin
          ram_wdata = best_r;
          pos_nxt   = pos_x2[CW-1:0];
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    left_r     <= left_nxt;
  end

  // a result is only strobed once the walk has finished
  a_valid_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count beyond depth");

  // the hole always lies inside the live heap during a walk
  a_hole_in_heap : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != S_POP_RD && state_r != S_POP_LOAD)
      |-> (pos_r >= CW'(1) && pos_r <= count_r))
    else $error("hole outside heap");

  a_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.action == ACT_POP && count_r == '0)
      |=> (out_valid && out_word.status == ST_EMPTY))
    else $error("pop on empty not reported next cycle");

endmodule

`default_nettype wire
